>>> design/page_frame_allocator_macros.svh
// Assertion macros used by the page frame allocator top level
`ifndef PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define PFA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define PFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/pfa_pkg.sv
// Types, constants and helper functions of the page frame allocator
package pfa_pkg;

    localparam int WORD_BITS       = 32;
    localparam int WORDS_PER_GROUP = 32;
    localparam int GROUP_SIZE      = 1024;
    localparam int PAGE_SHIFT      = 12;
    localparam int GROUP_SHIFT     = 10;
    localparam int BIT_SHIFT       = 5;
    localparam logic [31:0] ENTRY_FLAGS    = 32'h3;
    localparam logic [31:0] DIR_FIRST_SLOT = 32'h100;
    localparam logic [31:0] FRAME_BASE_RST = 32'h0040_0000;
    localparam logic [31:0] TABLE_BASE_RST = 32'h0;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_FRAME = 2'd1,
        STATUS_RANGE    = 2'd2
    } t_status;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } t_kind;

    typedef enum logic {
        CFG_FRAME_BASE = 1'b0,
        CFG_TABLE_BASE = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_SUM,
        S_WORD,
        S_FREE,
        S_FAIL
    } t_state;

    // per-group summary: one bit per bitmap word
    typedef struct packed {
        logic [WORD_BITS-1:0] nonzero;
        logic [WORD_BITS-1:0] full;
    } t_sum;

    typedef struct packed {
        logic rd_sum;
        logic rd_word;
        logic wr;
    } t_map_ctl;

    typedef struct packed {
        logic       found;
        logic [4:0] pos;
    } t_zero;

    // lowest clear bit of a word
    function automatic t_zero lowest_zero(input logic [WORD_BITS-1:0] v);
        t_zero r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!v[i]) begin
                r.found = 1'b1;
                r.pos   = 5'(i);
            end
        end
        return r;
    endfunction

endpackage

>>> design/page_frame_allocator.sv
// Top level of the page frame allocator: request sequencer, result register and config
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+------------------------------------
//  in      | in        | i_in_valid / o_in_stall     | i_kind, i_frame
//  out     | out       | o_out_valid / i_out_stall   | o_status .. o_dir_value
//  cfg     | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// Allocate steps through group search, summary read and bitmap read, then write-back and result.
// Free reads bitmap and summary together, then does write-back and result.
// After reset the block clears one bitmap word per cycle over all NUM_WORDS words, stalling input.
// One word is in work at a time; the write-back waits while a previous result sits stalled.
module page_frame_allocator #(
    parameter int NUM_FRAMES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [11:0] i_frame,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [11:0] o_frame_index,
    output logic [31:0] o_frame_address,
    output logic [31:0] o_entry_value,
    output logic        o_dir_write,
    output logic [9:0]  o_dir_slot,
    output logic [31:0] o_dir_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

`include "page_frame_allocator_macros.svh"

    localparam int NUM_WORDS  = (NUM_FRAMES + pfa_pkg::WORD_BITS - 1) / pfa_pkg::WORD_BITS;
    localparam int NUM_GROUPS = (NUM_FRAMES + pfa_pkg::GROUP_SIZE - 1) / pfa_pkg::GROUP_SIZE;
    localparam int WAW        = $clog2(NUM_WORDS);
    localparam int GW         = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int FW         = WAW + pfa_pkg::BIT_SHIFT;

    pfa_pkg::t_state  r_state, n_state;
    logic [31:0]      r_frame_base;
    logic [31:0]      r_table_base;
    logic [WAW-1:0]   r_word_addr;
    logic [GW-1:0]    r_group;
    logic [4:0]       r_pos_w;
    logic [4:0]       r_bit;
    pfa_pkg::t_status r_fail_status;
    logic [11:0]      r_fail_index;

    logic             r_out_valid;
    pfa_pkg::t_status r_status;
    logic [11:0]      r_frame_index;
    logic [31:0]      r_frame_address;
    logic [31:0]      r_entry_value;
    logic             r_dir_write;
    logic [9:0]       r_dir_slot;
    logic [31:0]      r_dir_value;

    pfa_pkg::t_map_ctl             map_ctl;
    logic [WAW-1:0]                map_word_addr;
    logic [GW-1:0]                 map_group_addr;
    logic [pfa_pkg::WORD_BITS-1:0] word_rdata;
    pfa_pkg::t_sum                 sum_rdata;
    logic                          map_busy;
    logic                          srch_found;
    logic [GW-1:0]                 srch_group;

    logic                          in_accept;
    logic [31:0]                   in_frame32;
    logic                          in_range;
    logic [GW-1:0]                 in_group;
    pfa_pkg::t_zero                sum_z;
    pfa_pkg::t_zero                word_z;
    logic [GW+4:0]                 wa_wide;
    logic                          wa_ok;
    logic [4:0]                    fin_bit;
    logic [FW-1:0]                 fin_idx;
    logic [31:0]                   fin_idx32;
    logic                          idx_ok;
    logic [pfa_pkg::WORD_BITS-1:0] bit_mask;
    logic [pfa_pkg::WORD_BITS-1:0] new_word;
    pfa_pkg::t_sum                 new_sum;
    logic                          grp_full;
    logic                          grp_empty;
    logic                          out_free;
    logic                          load_ok;
    logic                          load_fail;
    logic                          is_alloc;
    logic [31:0]                   fin_addr;
    logic [31:0]                   group32;

    pfa_map #(
        .NUM_WORDS  (NUM_WORDS),
        .NUM_GROUPS (NUM_GROUPS),
        .WAW        (WAW),
        .GW         (GW)
    ) u_map (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (map_ctl),
        .i_word_addr  (map_word_addr),
        .i_group_addr (map_group_addr),
        .i_word_wdata (new_word),
        .i_sum_wdata  (new_sum),
        .o_word_rdata (word_rdata),
        .o_sum_rdata  (sum_rdata),
        .o_busy       (map_busy)
    );

    pfa_group_search #(
        .NUM_GROUPS (NUM_GROUPS),
        .GW         (GW)
    ) u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_upd_en    (load_ok),
        .i_upd_group (r_group),
        .i_upd_full  (grp_full),
        .o_found     (srch_found),
        .o_group     (srch_group)
    );

    assign o_in_stall  = (r_state != pfa_pkg::S_IDLE) || map_busy;
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign in_frame32  = 32'(i_frame);
    assign in_range    = in_frame32 < 32'(NUM_FRAMES);
    assign in_group    = in_frame32[GW+pfa_pkg::GROUP_SHIFT-1:pfa_pkg::GROUP_SHIFT];
    assign out_free    = !r_out_valid || !i_out_stall;
    assign is_alloc    = (r_state == pfa_pkg::S_WORD);

    // summary gives the first word with room in the chosen group
    assign sum_z   = pfa_pkg::lowest_zero(sum_rdata.full);
    assign wa_wide = {r_group, sum_z.pos};
    assign wa_ok   = 32'(wa_wide) < 32'(NUM_WORDS);

    assign word_z    = pfa_pkg::lowest_zero(word_rdata);
    assign fin_bit   = is_alloc ? word_z.pos : r_bit;
    assign fin_idx   = {r_word_addr, fin_bit};
    assign fin_idx32 = 32'(fin_idx);
    assign idx_ok    = word_z.found && (fin_idx32 < 32'(NUM_FRAMES));

    assign bit_mask = pfa_pkg::WORD_BITS'(1) << fin_bit;
    assign new_word = is_alloc ? (word_rdata | bit_mask) : (word_rdata & ~bit_mask);

    always_comb begin
        new_sum                  = sum_rdata;
        new_sum.full[r_pos_w]    = &new_word;
        new_sum.nonzero[r_pos_w] = |new_word;
    end

    assign grp_full  = is_alloc && (&new_sum.full);
    assign grp_empty = ~|new_sum.nonzero;

    assign fin_addr = r_frame_base + (fin_idx32 << pfa_pkg::PAGE_SHIFT);
    assign group32  = 32'(r_group);

    // next state and memory control
    always_comb begin
        n_state        = r_state;
        map_ctl        = '0;
        map_word_addr  = r_word_addr;
        map_group_addr = r_group;
        load_ok        = 1'b0;
        load_fail      = 1'b0;
        unique case (r_state)
            pfa_pkg::S_IDLE: begin
                map_word_addr  = in_frame32[FW-1:pfa_pkg::BIT_SHIFT];
                map_group_addr = in_group;
                if (in_accept) begin
                    if (i_kind == pfa_pkg::KIND_ALLOC) begin
                        n_state = pfa_pkg::S_FIND;
                    end else if (in_range) begin
                        map_ctl.rd_sum  = 1'b1;
                        map_ctl.rd_word = 1'b1;
                        n_state         = pfa_pkg::S_FREE;
                    end else begin
                        n_state = pfa_pkg::S_FAIL;
                    end
                end
            end
            pfa_pkg::S_FIND: begin
                map_group_addr = srch_group;
                if (srch_found) begin
                    map_ctl.rd_sum = 1'b1;
                    n_state        = pfa_pkg::S_SUM;
                end else begin
                    n_state = pfa_pkg::S_FAIL;
                end
            end
            pfa_pkg::S_SUM: begin
                map_word_addr = wa_wide[WAW-1:0];
                if (sum_z.found && wa_ok) begin
                    map_ctl.rd_word = 1'b1;
                    n_state         = pfa_pkg::S_WORD;
                end else begin
                    n_state = pfa_pkg::S_FAIL;
                end
            end
            pfa_pkg::S_WORD: begin
                if (!idx_ok) begin
                    n_state = pfa_pkg::S_FAIL;
                end else if (out_free) begin
                    map_ctl.wr = 1'b1;
                    load_ok    = 1'b1;
                    n_state    = pfa_pkg::S_IDLE;
                end
            end
            pfa_pkg::S_FREE: begin
                if (out_free) begin
                    map_ctl.wr = 1'b1;
                    load_ok    = 1'b1;
                    n_state    = pfa_pkg::S_IDLE;
                end
            end
            pfa_pkg::S_FAIL: begin
                if (out_free) begin
                    load_fail = 1'b1;
                    n_state   = pfa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pfa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base <= pfa_pkg::FRAME_BASE_RST;
            r_table_base <= pfa_pkg::TABLE_BASE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (pfa_pkg::t_cfg_reg'(i_cfg_index))
                pfa_pkg::CFG_FRAME_BASE: r_frame_base <= i_cfg_data;
                pfa_pkg::CFG_TABLE_BASE: r_table_base <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // working registers of the word in flight
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            pfa_pkg::S_IDLE: begin
                r_word_addr   <= in_frame32[FW-1:pfa_pkg::BIT_SHIFT];
                r_group       <= in_group;
                r_pos_w       <= in_frame32[pfa_pkg::GROUP_SHIFT-1:pfa_pkg::BIT_SHIFT];
                r_bit         <= in_frame32[pfa_pkg::BIT_SHIFT-1:0];
                r_fail_status <= pfa_pkg::STATUS_RANGE;
                r_fail_index  <= i_frame;
            end
            pfa_pkg::S_FIND: begin
                r_group       <= srch_group;
                r_fail_status <= pfa_pkg::STATUS_NO_FRAME;
                r_fail_index  <= '0;
            end
            pfa_pkg::S_SUM: begin
                r_pos_w     <= sum_z.pos;
                r_word_addr <= wa_wide[WAW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_ok || load_fail) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_ok) begin
            r_status        <= pfa_pkg::STATUS_OK;
            r_frame_index   <= fin_idx32[11:0];
            r_frame_address <= fin_addr;
            r_dir_slot      <= 10'(pfa_pkg::DIR_FIRST_SLOT + group32);
            if (is_alloc) begin
                r_entry_value <= fin_addr | pfa_pkg::ENTRY_FLAGS;
                r_dir_write   <= 1'b1;
                r_dir_value   <= (r_table_base + (group32 << pfa_pkg::PAGE_SHIFT))
                                 | pfa_pkg::ENTRY_FLAGS;
            end else begin
                r_entry_value <= '0;
                r_dir_write   <= grp_empty;
                r_dir_value   <= '0;
            end
        end else if (load_fail) begin
            r_status        <= r_fail_status;
            r_frame_index   <= r_fail_index;
            r_frame_address <= '0;
            r_entry_value   <= '0;
            r_dir_write     <= 1'b0;
            r_dir_slot      <= '0;
            r_dir_value     <= '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_frame_index   = r_frame_index;
    assign o_frame_address = r_frame_address;
    assign o_entry_value   = r_entry_value;
    assign o_dir_write     = r_dir_write;
    assign o_dir_slot      = r_dir_slot;
    assign o_dir_value     = r_dir_value;

    `PFA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_accept, o_in_stall, "input taken while a word is in work")
    `PFA_ASSERT_SAME(a_group_has_room, i_clk, i_rst_n, r_state == pfa_pkg::S_SUM, !(&sum_rdata.full), "search picked a group whose summary is full")
    `PFA_ASSERT_SAME(a_word_has_room, i_clk, i_rst_n, r_state == pfa_pkg::S_WORD, word_z.found, "summary picked a full bitmap word")
    `PFA_ASSERT_NEXT(a_write_gives_result, i_clk, i_rst_n, map_ctl.wr, r_out_valid, "map write-back without a result")

endmodule

>>> design/pfa_map.sv
// Used-frame bitmap and per-group summary memories with the reset clearing sweep
module pfa_map #(
    parameter int NUM_WORDS  = 128,
    parameter int NUM_GROUPS = 4,
    parameter int WAW        = 7,
    parameter int GW         = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pfa_pkg::t_map_ctl              i_ctl,
    input  logic [WAW-1:0]                 i_word_addr,
    input  logic [GW-1:0]                  i_group_addr,
    input  logic [pfa_pkg::WORD_BITS-1:0]  i_word_wdata,
    input  pfa_pkg::t_sum                  i_sum_wdata,
    output logic [pfa_pkg::WORD_BITS-1:0]  o_word_rdata,
    output pfa_pkg::t_sum                  o_sum_rdata,
    output logic                           o_busy
);

    localparam logic [WAW:0] NW_L = (WAW+1)'(NUM_WORDS);
    localparam logic [WAW:0] NG_L = (WAW+1)'(NUM_GROUPS);

    logic [pfa_pkg::WORD_BITS-1:0] mem_word [NUM_WORDS];
    pfa_pkg::t_sum                 mem_sum  [NUM_GROUPS];

    logic [WAW:0]                  r_clr_cnt;
    logic [pfa_pkg::WORD_BITS-1:0] r_word_q;
    pfa_pkg::t_sum                 r_sum_q;
    logic                          clearing;

    assign clearing = (r_clr_cnt < NW_L);
    assign o_busy   = clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (clearing) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (clearing) begin
            mem_word[r_clr_cnt[WAW-1:0]] <= '0;
        end else if (i_ctl.wr) begin
            mem_word[i_word_addr] <= i_word_wdata;
        end
        if (i_ctl.rd_word) begin
            r_word_q <= mem_word[i_word_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (clearing) begin
            if (r_clr_cnt < NG_L) begin
                mem_sum[r_clr_cnt[GW-1:0]] <= '0;
            end
        end else if (i_ctl.wr) begin
            mem_sum[i_group_addr] <= i_sum_wdata;
        end
        if (i_ctl.rd_sum) begin
            r_sum_q <= mem_sum[i_group_addr];
        end
    end

    assign o_word_rdata = r_word_q;
    assign o_sum_rdata  = r_sum_q;

endmodule

>>> design/pfa_group_search.sv
// Group-full flags and the registered search for the lowest group with room
module pfa_group_search #(
    parameter int NUM_GROUPS = 4,
    parameter int GW         = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_upd_en,
    input  logic [GW-1:0] i_upd_group,
    input  logic          i_upd_full,
    output logic          o_found,
    output logic [GW-1:0] o_group
);

    localparam int NC = (NUM_GROUPS + pfa_pkg::WORD_BITS - 1) / pfa_pkg::WORD_BITS;

    logic [NUM_GROUPS-1:0]               r_full;
    logic [NC*pfa_pkg::WORD_BITS-1:0]    padded;
    pfa_pkg::t_zero                      r_chunk [NC];

    // groups past the end count as full
    for (genvar g = 0; g < NC * pfa_pkg::WORD_BITS; g++) begin : g_pad
        if (g < NUM_GROUPS) begin : g_real
            assign padded[g] = r_full[g];
        end else begin : g_fill
            assign padded[g] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= '0;
        end else if (i_upd_en) begin
            r_full[i_upd_group] <= i_upd_full;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NC; c++) begin
            r_chunk[c] <= pfa_pkg::lowest_zero(padded[c*pfa_pkg::WORD_BITS +: pfa_pkg::WORD_BITS]);
        end
    end

    always_comb begin
        o_found = 1'b0;
        o_group = '0;
        for (int c = NC - 1; c >= 0; c--) begin
            if (r_chunk[c].found) begin
                o_found = 1'b1;
                o_group = GW'(c * pfa_pkg::WORD_BITS + int'(r_chunk[c].pos));
            end
        end
    end

endmodule

>>> test/page_frame_allocator_tb.sv
// Self-checking bench for the first-fit page frame allocator: random and directed requests
`timescale 1ns / 1ps

module page_frame_allocator_tb;

    localparam int CLK_PERIOD  = 12;
    localparam int POOL_FRAMES = 4096;
    localparam int POOL_GROUPS = (POOL_FRAMES + pfa_pkg::GROUP_SIZE - 1) / pfa_pkg::GROUP_SIZE;
    localparam int MAX_IDLE    = 14;
    localparam int TAIL_CYCLES = 20;
    localparam longint TIMEOUT_NS = 64'd2_400_000;

    typedef struct packed {
        pfa_pkg::t_kind kind;
        logic [11:0]    frame;
    } t_frame_request;

    typedef struct packed {
        pfa_pkg::t_status status;
        logic [11:0]      index;
        logic [31:0]      addr;
        logic [31:0]      entry;
        logic             dir_wr;
        logic [9:0]       slot;
        logic [31:0]      dir_val;
    } t_frame_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_kind = 1'b0;
    logic [11:0] in_frame = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [11:0] o_frame_index;
    logic [31:0] o_frame_address;
    logic [31:0] o_entry_value;
    logic        o_dir_write;
    logic [9:0]  o_dir_slot;
    logic [31:0] o_dir_value;
    logic        o_cfg_ready;

    // predictor state
    bit          frame_used [POOL_FRAMES];
    int          group_load [POOL_GROUPS];
    int          frames_in_use = 0;
    logic [31:0] frame_base_cfg = pfa_pkg::FRAME_BASE_RST;
    logic [31:0] table_base_cfg = pfa_pkg::TABLE_BASE_RST;

    t_frame_request pending_requests[$];
    t_frame_result  frame_results[$];
    int mismatches = 0;
    bit send_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;

    page_frame_allocator #(
        .NUM_FRAMES(POOL_FRAMES)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (in_kind),
        .i_frame        (in_frame),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_status       (o_status),
        .o_frame_index  (o_frame_index),
        .o_frame_address(o_frame_address),
        .o_entry_value  (o_entry_value),
        .o_dir_write    (o_dir_write),
        .o_dir_slot     (o_dir_slot),
        .o_dir_value    (o_dir_value),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Apply one request to the frame map and return the word the block should produce.
    function automatic t_frame_result book_request(input pfa_pkg::t_kind kind,
                                                   input logic [11:0] frame);
        t_frame_result r;
        int idx;
        int grp;
        r = '0;
        r.status = pfa_pkg::STATUS_OK;
        if (kind == pfa_pkg::KIND_ALLOC) begin
            idx = 0;
            while (idx < POOL_FRAMES && frame_used[idx])
                idx++;
            if (idx >= POOL_FRAMES) begin
                r.status = pfa_pkg::STATUS_NO_FRAME;
                return r;
            end
            grp = idx / pfa_pkg::GROUP_SIZE;
            frame_used[idx] = 1'b1;
            group_load[grp]++;
            frames_in_use++;
            r.index   = 12'(idx);
            r.addr    = frame_base_cfg + (32'(idx) << pfa_pkg::PAGE_SHIFT);
            r.entry   = r.addr | pfa_pkg::ENTRY_FLAGS;
            r.dir_wr  = 1'b1;
            r.slot    = 10'(pfa_pkg::DIR_FIRST_SLOT + 32'(grp));
            r.dir_val = (table_base_cfg + (32'(grp) << pfa_pkg::PAGE_SHIFT))
                        | pfa_pkg::ENTRY_FLAGS;
            return r;
        end
        idx = int'(frame);
        r.index = frame;
        if (idx >= POOL_FRAMES) begin
            r.status = pfa_pkg::STATUS_RANGE;
            return r;
        end
        grp = idx / pfa_pkg::GROUP_SIZE;
        if (frame_used[idx]) begin
            frame_used[idx] = 1'b0;
            group_load[grp]--;
            frames_in_use--;
        end
        r.addr   = frame_base_cfg + (32'(idx) << pfa_pkg::PAGE_SHIFT);
        r.dir_wr = (group_load[grp] == 0);
        r.slot   = 10'(pfa_pkg::DIR_FIRST_SLOT + 32'(grp));
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : request_driver
        t_frame_request req;
        int gap_left;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_valid && !o_in_stall)
                frame_results.push_back(book_request(pfa_pkg::t_kind'(in_kind), in_frame));
            // hold a stalled word, otherwise advance
            if (!in_valid || !o_in_stall) begin
                if (gap_left == 0 && pending_requests.size() > 0) begin
                    req = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    in_kind  <= req.kind;
                    in_frame <= req.frame;
                    gap_left = send_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
                end else begin
                    if (gap_left > 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_frame_result want;
        int stall_left;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (frame_results.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got status %0d index %0h",
                             $time, o_status, o_frame_index);
                    mismatches++;
                end else begin
                    want = frame_results.pop_front();
                    compare_field("status", 32'(want.status), 32'(o_status));
                    compare_field("frame_index", 32'(want.index), 32'(o_frame_index));
                    compare_field("frame_address", want.addr, o_frame_address);
                    compare_field("entry_value", want.entry, o_entry_value);
                    compare_field("dir_write", 32'(want.dir_wr), 32'(o_dir_write));
                    compare_field("dir_slot", 32'(want.slot), 32'(o_dir_slot));
                    compare_field("dir_value", want.dir_val, o_dir_value);
                end
                stall_left = recv_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(input pfa_pkg::t_cfg_reg sel, input logic [31:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (sel == pfa_pkg::CFG_FRAME_BASE)
            frame_base_cfg = value;
        else
            table_base_cfg = value;
    endtask

    // Wait until every queued word is sent and every result is back.
    task automatic drain;
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || in_valid || frame_results.size() != 0);
    endtask

    task automatic push_req(input pfa_pkg::t_kind kind, input logic [11:0] frame);
        pending_requests.push_back('{kind: kind, frame: frame});
    endtask

    // Mostly allocations, frees aimed at the packed low end of the pool, some anywhere.
    task automatic queue_random(input int count);
        int span;
        span = frames_in_use;
        repeat (count) begin
            if ($urandom_range(0, 99) < 55) begin
                push_req(pfa_pkg::KIND_ALLOC, 12'($urandom));
                if (span < POOL_FRAMES - 1)
                    span++;
            end else if ($urandom_range(0, 1) == 1) begin
                push_req(pfa_pkg::KIND_FREE, 12'($urandom_range(0, span)));
                if (span > 0)
                    span--;
            end else begin
                push_req(pfa_pkg::KIND_FREE, 12'($urandom));
            end
        end
    endtask

    initial begin : run_phases
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(pfa_pkg::CFG_FRAME_BASE, pfa_pkg::FRAME_BASE_RST);
        write_reg(pfa_pkg::CFG_TABLE_BASE, 32'h0010_0000);

        push_req(pfa_pkg::KIND_ALLOC, 12'h000);
        push_req(pfa_pkg::KIND_ALLOC, 12'h555);
        push_req(pfa_pkg::KIND_ALLOC, 12'hFFF);
        push_req(pfa_pkg::KIND_FREE, 12'h001);   // group stays in use
        push_req(pfa_pkg::KIND_ALLOC, 12'hAAA);  // lowest free is frame 1 again
        push_req(pfa_pkg::KIND_FREE, 12'hFFF);   // already free, top group empty
        push_req(pfa_pkg::KIND_FREE, 12'h800);
        push_req(pfa_pkg::KIND_FREE, 12'h400);
        push_req(pfa_pkg::KIND_FREE, 12'h000);
        push_req(pfa_pkg::KIND_FREE, 12'h001);
        push_req(pfa_pkg::KIND_FREE, 12'h002);   // empties group 0
        push_req(pfa_pkg::KIND_FREE, 12'h002);
        push_req(pfa_pkg::KIND_FREE, 12'h555);
        push_req(pfa_pkg::KIND_FREE, 12'hAAA);
        push_req(pfa_pkg::KIND_ALLOC, 12'h000);
        push_req(pfa_pkg::KIND_ALLOC, 12'h3FF);
        drain();

        // frame base near the top, so frame address sums wrap
        write_reg(pfa_pkg::CFG_FRAME_BASE, 32'hFFFF_F000);
        write_reg(pfa_pkg::CFG_TABLE_BASE, 32'hFFFF_FFFF);
        push_req(pfa_pkg::KIND_ALLOC, 12'h000);
        push_req(pfa_pkg::KIND_ALLOC, 12'h000);
        queue_random(180);
        drain();

        write_reg(pfa_pkg::CFG_FRAME_BASE, $urandom);
        write_reg(pfa_pkg::CFG_TABLE_BASE, $urandom);
        queue_random(180);
        drain();

        // back to back on both sides
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        write_reg(pfa_pkg::CFG_FRAME_BASE, 32'h0);
        write_reg(pfa_pkg::CFG_TABLE_BASE, 32'h0);
        push_req(pfa_pkg::KIND_FREE, 12'h400);
        push_req(pfa_pkg::KIND_FREE, 12'hFFF);
        push_req(pfa_pkg::KIND_ALLOC, 12'h000);
        push_req(pfa_pkg::KIND_ALLOC, 12'h000);
        push_req(pfa_pkg::KIND_ALLOC, 12'h000);
        queue_random(60);
        drain();

        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        write_reg(pfa_pkg::CFG_FRAME_BASE, 32'hFFFF_FFFF);
        write_reg(pfa_pkg::CFG_TABLE_BASE, $urandom);
        queue_random(60);
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("page_frame_allocator_tb: clean");
        else
            $display("page_frame_allocator_tb: errors");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("page_frame_allocator_tb: errors");
        $finish;
    end

endmodule
